FILE: hw/rtl/tfp_pkg.sv
// shared types, constants and crc helper for the telemetry frame packer
package tfp_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;

  // frame layout
  localparam int FRAME_LEN = 22;
  localparam int PAY_LEN   = 18;
  localparam int IDX_W     = 5;

  localparam logic [IDX_W-1:0] IDX_HDR0      = 5'd0;
  localparam logic [IDX_W-1:0] IDX_HDR1      = 5'd1;
  localparam logic [IDX_W-1:0] IDX_PAY_FIRST = 5'd2;
  localparam logic [IDX_W-1:0] IDX_PAY_LAST  = 5'd19;
  localparam logic [IDX_W-1:0] IDX_CRC_HI    = 5'd20;
  localparam logic [IDX_W-1:0] IDX_CRC_LO    = 5'd21;

  localparam logic [7:0] HDR0_BYTE = 8'hAA;
  localparam logic [7:0] HDR1_BYTE = 8'hBB;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // scaled fields
  localparam int NUM_FIELDS = 5;
  localparam int FLD_X      = 0;
  localparam int FLD_Y      = 1;
  localparam int FLD_YAW    = 2;
  localparam int FLD_FRONT  = 3;
  localparam int FLD_REAR   = 4;

  localparam int VAL_W   = 33;
  localparam int SCALE_W = 11;
  localparam int PROD_W  = VAL_W + SCALE_W;

  localparam logic [SCALE_W-1:0] SCALE_POS = 11'd2000;
  localparam logic [SCALE_W-1:0] SCALE_YAW = 11'd100;

  localparam logic [15:0] SAT_MAX = 16'h7FFF;
  localparam logic [15:0] SAT_MIN = 16'h8000;

  // configuration registers
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIFT_EN = 4'd1;

  typedef struct packed {
    logic [31:0] tick;
    logic [15:0] action;
    logic [15:0] link;
  } tfp_side_t;

  typedef struct packed {
    logic en_abs;
    logic en_mul;
    logic en_sat;
  } tfp_lane_ctrl_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/tfp_front.sv
// input capture stage: widens the fields and forms the two height sums
module tfp_front import tfp_pkg::*; (
  input  logic                                clk,
  input  logic                                en,
  input  logic [31:0]                         tick_ms,
  input  logic [31:0]                         pos_x,
  input  logic [31:0]                         pos_y,
  input  logic [31:0]                         heading,
  input  logic [31:0]                         lift_front,
  input  logic [31:0]                         lift_rear,
  input  logic                                lift_ready,
  input  logic [15:0]                         action_flags,
  input  logic [15:0]                         link_flags,
  input  logic [31:0]                         grounding_height,
  input  logic                                lift_enable,
  output logic [NUM_FIELDS-1:0][VAL_W-1:0]    val,
  output tfp_side_t                           side
);

  logic             use_lift;
  logic [VAL_W-1:0] base;
  logic [VAL_W-1:0] add_front;
  logic [VAL_W-1:0] add_rear;

  always_comb begin
    use_lift  = lift_enable & lift_ready;
    base      = {grounding_height[31], grounding_height};
    add_front = use_lift ? {lift_front[31], lift_front} : '0;
    add_rear  = use_lift ? {lift_rear[31], lift_rear} : '0;
  end

  // sums of two sign-extended 32-bit values fit 33 bits without wrap
  always_ff @(posedge clk) begin
    if (en) begin
      val[FLD_X]     <= {pos_x[31], pos_x};
      val[FLD_Y]     <= {pos_y[31], pos_y};
      val[FLD_YAW]   <= {heading[31], heading};
      val[FLD_FRONT] <= base + add_front;
      val[FLD_REAR]  <= base + add_rear;
      side.tick      <= tick_ms;
      side.action    <= action_flags;
      side.link      <= link_flags;
    end
  end

endmodule

FILE: hw/rtl/tfp_lane.sv
// one scaling lane: magnitude, multiply, round half away and saturate
module tfp_lane import tfp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                 clk,
  input  tfp_lane_ctrl_t       ctrl,
  input  logic [VAL_W-1:0]     value,
  input  logic [SCALE_W-1:0]   scale,
  output logic [15:0]          result
);

  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic               neg_a;
  logic [VAL_W-1:0]   mag_a;
  logic               neg_b;
  logic [PROD_W-1:0]  prod_b;
  logic [PROD_W-1:0]  q;
  logic [15:0]        result_next;

  always_comb begin
    q = (prod_b + HALF) >> FRAC_BITS;
    if (neg_b) begin
      result_next = (q > PROD_W'(32768)) ? SAT_MIN : (16'h0000 - q[15:0]);
    end else begin
      result_next = (q > PROD_W'(32767)) ? SAT_MAX : q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_abs) begin
      neg_a <= value[VAL_W-1];
      mag_a <= value[VAL_W-1] ? (~value + VAL_W'(1)) : value;
    end
    if (ctrl.en_mul) begin
      neg_b  <= neg_a;
      prod_b <= PROD_W'(mag_a) * PROD_W'(scale);
    end
    if (ctrl.en_sat) begin
      result <= result_next;
    end
  end

endmodule

FILE: hw/rtl/tfp_serializer.sv
// frame buffer and byte serializer with running crc
module tfp_serializer import tfp_pkg::*; (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             frame_valid,
  input  logic [NUM_FIELDS-1:0][15:0]      fields,
  input  tfp_side_t                        side,
  output logic                             take,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       frame_byte,
  output logic [IDX_W-1:0]                 byte_index,
  output logic                             last_byte
);

  logic [PAY_LEN-1:0][7:0] pay;
  logic                    busy;
  logic [IDX_W-1:0]        idx;
  logic [15:0]             crc;

  logic             load;
  logic             last_load;
  logic             is_pay;
  logic [IDX_W-1:0] sel;
  logic [7:0]       byte_next;

  always_comb begin
    load      = !out_valid || !out_stall;
    last_load = busy && load && (idx == IDX_CRC_LO);
    take      = !busy || last_load;
    is_pay    = (idx >= IDX_PAY_FIRST) && (idx <= IDX_PAY_LAST);
    sel       = IDX_PAY_LAST - idx;
    case (idx)
      IDX_HDR0:   byte_next = HDR0_BYTE;
      IDX_HDR1:   byte_next = HDR1_BYTE;
      IDX_CRC_HI: byte_next = crc[15:8];
      IDX_CRC_LO: byte_next = crc[7:0];
      default:    byte_next = pay[sel];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= busy;
      if (take) busy <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && busy) begin
      frame_byte <= byte_next;
      byte_index <= idx;
      last_byte  <= (idx == IDX_CRC_LO);
    end
    // a new frame restarts the index and crc, else the current one advances
    if (take && frame_valid) begin
      pay <= {side.tick, fields[FLD_X], fields[FLD_Y], fields[FLD_YAW],
              fields[FLD_FRONT], fields[FLD_REAR], side.action, side.link};
      idx <= IDX_HDR0;
      crc <= CRC_INIT;
    end else if (load && busy) begin
      crc <= is_pay ? crc16_byte(crc, byte_next) : crc;
      idx <= idx + IDX_W'(1);
    end
  end

  a_last_is_crc_lo: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> byte_index == IDX_CRC_LO)
    else $error("last_byte on a byte other than crc low");

  a_no_gap_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_byte |=> out_valid)
    else $error("gap inside a frame");

  a_header_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_index == IDX_HDR0 |-> frame_byte == HDR0_BYTE)
    else $error("frame does not open with header");

  a_take_when_done: assert property (@(posedge clk) disable iff (rst)
    busy && !take |=> busy)
    else $error("serializer dropped a frame early");

endmodule

FILE: hw/rtl/telemetry_frame_packer_crc16_top.sv
// top level of the telemetry frame packer with crc-16/modbus
//
// usage
//   input channel: one telemetry snapshot per word (in_valid / in_stall);
//   a word is taken at a clock edge with in_valid high and in_stall low
//   output channel: one frame byte per word (out_valid / out_stall), 22
//   words per snapshot: header aa bb, tick, x, y, yaw, front and rear
//   height, action and link flags, crc high then low; last_byte marks
//   the crc low byte
//   config channel: cfg_valid / cfg_ready, cfg_index 0 grounding height,
//   1 lift enable; other indexes are ignored; write only while idle
// latency: first byte of a frame is valid 5 cycles after its snapshot
//   is taken when the serializer is free
// throughput: one snapshot per 22 cycles, set by the one-byte output
//   port; the 4-stage pipe takes a snapshot every cycle until it fills
// reset: rst is synchronous; all pipe and output valids clear,
//   grounding height goes to 0 and lift enable to 1
// stall: out_stall freezes the output byte; the pipe keeps filling and
//   in_stall rises once all stages hold a snapshot; nothing is lost
module telemetry_frame_packer_crc16_top import tfp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // snapshot channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           tick_ms,
  input  logic [31:0]           pos_x,
  input  logic [31:0]           pos_y,
  input  logic [31:0]           heading,
  input  logic [31:0]           lift_front,
  input  logic [31:0]           lift_rear,
  input  logic                  lift_ready,
  input  logic [15:0]           action_flags,
  input  logic [15:0]           link_flags,
  // byte channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            frame_byte,
  output logic [IDX_W-1:0]      byte_index,
  output logic                  last_byte,
  // register write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data
);

  // configuration registers
  logic [31:0] grounding_height;
  logic        lift_enable;

  // stage valids: 1 capture, 2 magnitude, 3 multiply, 4 round/saturate
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  logic take;

  tfp_lane_ctrl_t                 lane_ctrl;
  logic [NUM_FIELDS-1:0][VAL_W-1:0] val1;
  logic [NUM_FIELDS-1:0][15:0]    res4;
  tfp_side_t                      side1, side2, side3, side4;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grounding_height <= 32'd0;
      lift_enable      <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GROUND:  grounding_height <= cfg_data;
        REG_LIFT_EN: lift_enable      <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en4      = !v4 || take;
    en3      = !v3 || en4;
    en2      = !v2 || en3;
    en1      = !v1 || en2;
    in_stall = !en1;
    lane_ctrl.en_abs = en2;
    lane_ctrl.en_mul = en3;
    lane_ctrl.en_sat = en4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // tick and flags ride alongside the lanes
  always_ff @(posedge clk) begin
    if (en2) side2 <= side1;
    if (en3) side3 <= side2;
    if (en4) side4 <= side3;
  end

  tfp_front u_front (
    .clk              (clk),
    .en               (en1),
    .tick_ms          (tick_ms),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .heading          (heading),
    .lift_front       (lift_front),
    .lift_rear        (lift_rear),
    .lift_ready       (lift_ready),
    .action_flags     (action_flags),
    .link_flags       (link_flags),
    .grounding_height (grounding_height),
    .lift_enable      (lift_enable),
    .val              (val1),
    .side             (side1)
  );

  for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_lane
    tfp_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .value  (val1[g]),
      .scale  ((g == FLD_YAW) ? SCALE_YAW : SCALE_POS),
      .result (res4[g])
    );
  end

  tfp_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (v4),
    .fields      (res4),
    .side        (side4),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_byte  (frame_byte),
    .byte_index  (byte_index),
    .last_byte   (last_byte)
  );

endmodule
